>>> hdl/tdad_pkg.sv
// Shared types and constants for the trackball edge to accelerated delta block.
package tdad_pkg;

   localparam int unsigned StampWidth = 16;
   localparam int unsigned BaseWidth  = 7;
   localparam int unsigned AccelWidth = 10;
   localparam int unsigned DeltaWidth = 12;
   localparam int unsigned DivSteps   = AccelWidth;
   localparam int unsigned CntWidth   = $clog2(DivSteps);

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic AXIS_Y = 1'b0;
   localparam logic AXIS_X = 1'b1;

   localparam logic REG_BASE_STEP    = 1'b0;
   localparam logic REG_ACCEL_FACTOR = 1'b1;

   localparam logic [BaseWidth-1:0]  BASE_RESET  = 7'd2;
   localparam logic [AccelWidth-1:0] ACCEL_RESET = 10'd100;

   typedef struct packed {
      logic                  level_up;
      logic                  level_down;
      logic                  level_left;
      logic                  level_right;
      logic [StampWidth-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                         axis;
      logic signed [DeltaWidth-1:0] delta;
      logic                         last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic load_axis;
      logic step;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic pend_y;
      logic pend_x;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> hdl/tdad_ctrl.sv
// Controller state machine sequencing capture, division and result emission.
module tdad_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tdad_pkg::dp_status_type status,
   output tdad_pkg::ctl_cmd_type   cmd
);
   import tdad_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (status.pend_y || status.pend_x) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_PICK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_PICK: begin
            cmd.load      = status.pend_y || status.pend_x;
            cmd.load_axis = status.pend_y ? AXIS_Y : AXIS_X;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

>>> hdl/tdad_datapath.sv
// Datapath: pin edge detect, timestamps, restoring divider and output register.
module tdad_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  tdad_pkg::req_type        req_data,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [tdad_pkg::AccelWidth-1:0] csr_wdata,
   input  tdad_pkg::ctl_cmd_type    cmd,
   output tdad_pkg::dp_status_type  status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tdad_pkg::rsp_type        rsp_data
);
   import tdad_pkg::*;

   logic [BaseWidth-1:0]  base_ff;
   logic [AccelWidth-1:0] accel_ff;
   logic [3:0]            prior_ff;
   logic [3:0]            chg_ff;
   logic [StampWidth-1:0] now_ff;
   logic                  pend_y_ff;
   logic                  pend_x_ff;
   logic [StampWidth-1:0] stamp_ff [4];
   logic [StampWidth-1:0] divisor_ff;
   logic [AccelWidth-1:0] rem_ff;
   logic [AccelWidth-1:0] quo_ff;
   logic [CntWidth-1:0]   cnt_ff;
   logic                  neg_ff;
   logic                  axis_ff;
   logic                  last_ff;
   logic                  div_end_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [3:0]            levels;
   logic [1:0]            dir;
   logic [StampWidth-1:0] elapsed;
   logic [StampWidth:0]   trial;
   logic                  fits;
   logic [BaseWidth+AccelWidth-7:0] unused_guard;
   logic [AccelWidth:0]   mag;
   logic [DeltaWidth-1:0] mag_ext;

   assign levels = {req_data.level_right, req_data.level_left,
                    req_data.level_down, req_data.level_up};

   always_comb begin
      if (cmd.load_axis == AXIS_X) begin
         dir = chg_ff[3] ? DIR_RIGHT : DIR_LEFT;
      end else begin
         dir = chg_ff[1] ? DIR_DOWN : DIR_UP;
      end
      elapsed = now_ff - stamp_ff[dir];
      if (elapsed == '0) begin
         elapsed = StampWidth'(1);
      end
   end

   assign trial = {(StampWidth + 1 - AccelWidth - 1)'(0), rem_ff, quo_ff[AccelWidth-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   assign unused_guard = '0;
   assign mag     = (AccelWidth + 1)'(base_ff) + {1'b0, quo_ff};
   assign mag_ext = {1'b0, mag} | DeltaWidth'(unused_guard);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         accel_ff  <= ACCEL_RESET;
         prior_ff  <= 4'hF;
         pend_y_ff <= 1'b0;
         pend_x_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_BASE_STEP:    base_ff  <= csr_wdata[BaseWidth-1:0];
               REG_ACCEL_FACTOR: accel_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.capture) begin
            prior_ff  <= levels;
            chg_ff    <= levels ^ prior_ff;
            now_ff    <= req_data.now_ms;
            pend_y_ff <= |(levels[1:0] ^ prior_ff[1:0]);
            pend_x_ff <= |(levels[3:2] ^ prior_ff[3:2]);
         end
         if (cmd.load) begin
            stamp_ff[dir] <= now_ff;
            if (cmd.load_axis == AXIS_X) begin
               pend_x_ff <= 1'b0;
            end else begin
               pend_y_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.step && !status.div_done) begin
         cnt_ff <= cnt_ff + CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         divisor_ff <= elapsed;
         rem_ff     <= '0;
         quo_ff     <= accel_ff;
         neg_ff     <= (dir == DIR_UP) || (dir == DIR_LEFT);
         axis_ff    <= cmd.load_axis;
         last_ff    <= (cmd.load_axis == AXIS_X) || !pend_x_ff;
      end else if (cmd.step && !status.div_done) begin
         rem_ff <= fits ? AccelWidth'(trial - {1'b0, divisor_ff}) : AccelWidth'(trial);
         quo_ff <= {quo_ff[AccelWidth-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_end_ff <= 1'b0;
      end else if (cmd.load) begin
         div_end_ff <= 1'b0;
      end else if (cmd.step && cnt_ff == CntWidth'(DivSteps - 1)) begin
         div_end_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.axis  <= axis_ff;
         rsp_data_ff.delta <= neg_ff ? (DeltaWidth'(0) - mag_ext) : mag_ext;
         rsp_data_ff.last  <= last_ff;
      end
   end

   assign status.pend_y   = pend_y_ff;
   assign status.pend_x   = pend_x_ff;
   assign status.div_done = div_end_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntWidth'(DivSteps))
      else $error("divider step count out of range");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

   a_load_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (pend_y_ff || pend_x_ff))
      else $error("axis loaded with nothing pending");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> div_end_ff)
      else $error("result emitted before division finished");

endmodule

>>> hdl/trackball_edge_to_accelerated_delta.sv
// Top level: trackball pin edges to accelerated signed movement deltas.
//
// Usage:
//   req channel: one scan per request (four pin levels and a 16-bit ms stamp),
//   accepted when req_valid is high and req_stall is low.
//   rsp channel: zero, one or two results per scan, y before x; last marks the
//   final result of the scan. A scan with no pin change gives no result.
//   csr port: csr_we writes csr_wdata into register csr_index
//   (0 base step, 1 acceleration numerator) at the clock edge; write only when idle.
// Sequencing:
//   The controller captures the scan, then each moving axis takes a load state,
//   the restoring divider (ten one-bit steps and a finish state) and an emit
//   state, which waits while the output register is still held.
//   Axes and scans take the shared divider in turn: a new scan is accepted only
//   after the previous scan is done; a scan with no movement skips the divider.
// Reset: synchronous, active high; pins read as high, stamps zero,
//   base step 2, acceleration numerator 100, no result pending.
// Stall: a result sits in the output register while rsp_stall is high; the
//   next scan may still be accepted and worked, and waits before its emit.
module trackball_edge_to_accelerated_delta (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tdad_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tdad_pkg::rsp_type       rsp_data,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [tdad_pkg::AccelWidth-1:0] csr_wdata
);
   import tdad_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   tdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tdad_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_trackball_edge_to_accelerated_delta.sv
// Self-checking testbench for the trackball edge to accelerated delta block.
module tb_trackball_edge_to_accelerated_delta;
   timeunit 1ns;
   timeprecision 1ps;

   import tdad_pkg::*;

   localparam int QuietLimit  = 4000;
   localparam int DrainCycles = 32;
   localparam int MaxGap      = 19;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic                  csr_index = REG_BASE_STEP;
   logic [AccelWidth-1:0] csr_wdata = '0;

   trackball_edge_to_accelerated_delta dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [BaseWidth-1:0]  base_reg   = BASE_RESET;
   logic [AccelWidth-1:0] accel_reg  = ACCEL_RESET;
   logic [3:0]            pin_memory = 4'hF;
   logic [StampWidth-1:0] stamp_mem [4] = '{default: '0};
   rsp_type               expected_moves [$];

   // stimulus state
   logic [3:0]            pin_levels = 4'hF;
   logic [StampWidth-1:0] scan_clock = '0;
   logic                  calm       = 1'b0;

   int mismatches   = 0;
   int quiet_cycles = 0;
   int stall_left   = 0;

   function automatic logic signed [DeltaWidth-1:0] move_for(logic [1:0] dir,
                                                             logic [StampWidth-1:0] now);
      logic [StampWidth-1:0] elapsed;
      logic [DeltaWidth-1:0] mag;
      elapsed = now - stamp_mem[dir];
      if (elapsed == '0) begin
         elapsed = 1;
      end
      stamp_mem[dir] = now;
      mag = base_reg + (accel_reg / elapsed);
      return (dir == DIR_UP || dir == DIR_LEFT) ? -mag : mag;
   endfunction

   function automatic int predict_scan(req_type scan);
      logic [3:0] lv;
      logic [3:0] changed;
      rsp_type    y_move;
      rsp_type    x_move;
      int         count;
      count = 0;
      lv = {scan.level_right, scan.level_left, scan.level_down, scan.level_up};
      changed = lv ^ pin_memory;
      pin_memory = lv;
      y_move = '0;
      x_move = '0;
      if (changed[1:0] != 2'b00) begin
         y_move.axis  = AXIS_Y;
         y_move.delta = move_for(changed[1] ? DIR_DOWN : DIR_UP, scan.now_ms);
      end
      if (changed[3:2] != 2'b00) begin
         x_move.axis  = AXIS_X;
         x_move.delta = move_for(changed[3] ? DIR_RIGHT : DIR_LEFT, scan.now_ms);
      end
      if (changed[1:0] != 2'b00) begin
         y_move.last = (changed[3:2] == 2'b00);
         expected_moves.push_back(y_move);
         count++;
      end
      if (changed[3:2] != 2'b00) begin
         x_move.last = 1'b1;
         expected_moves.push_back(x_move);
         count++;
      end
      return count;
   endfunction

   // flip the chosen pins and send one scan at the given stamp
   task automatic send_scan(input logic [3:0] flips, input logic [StampWidth-1:0] now,
                            output int produced);
      req_type scan;
      int      gap;
      logic    stalled;
      pin_levels = pin_levels ^ flips;
      scan.level_up    = pin_levels[0];
      scan.level_down  = pin_levels[1];
      scan.level_left  = pin_levels[2];
      scan.level_right = pin_levels[3];
      scan.now_ms      = now;
      gap = calm ? 0 : $urandom_range(MaxGap, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= scan;
      stalled = 1'b1;
      while (stalled) begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end
      produced = predict_scan(scan);
   endtask

   task automatic scan(input logic [3:0] flips, input logic [StampWidth-1:0] now);
      int produced;
      send_scan(flips, now, produced);
   endtask

   // hold requests until every expected result is back, then let the block settle
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic load_settings(input logic [AccelWidth-1:0] base_value,
                                input logic [AccelWidth-1:0] accel_value);
      csr_we    <= 1'b1;
      csr_index <= REG_BASE_STEP;
      csr_wdata <= base_value;
      @(posedge clock);
      base_reg = base_value[BaseWidth-1:0];
      csr_index <= REG_ACCEL_FACTOR;
      csr_wdata <= accel_value;
      @(posedge clock);
      accel_reg = accel_value;
      csr_we <= 1'b0;
   endtask

   task automatic test_basic_pulses;
      scan(4'b0000, 16'd5);
      scan(4'b0001, 16'd0);
      scan(4'b0010, 16'd3);
      scan(4'b0100, 16'd10);
      scan(4'b1000, 16'hFFFF);
      scan(4'b0101, 16'd40);
      scan(4'b0000, 16'd41);
   endtask

   task automatic test_axis_conflicts;
      scan(4'b0011, 16'd50);
      scan(4'b1100, 16'd52);
      scan(4'b1111, 16'd53);
      scan(4'b1010, 16'd60);
   endtask

   task automatic test_time_wrap;
      scan(4'b0010, 16'd60);
      scan(4'b0010, 16'd60);
      scan(4'b1000, 16'hFFFA);
      scan(4'b1000, 16'd4);
      scan(4'b0001, 16'hFFFF);
   endtask

   task automatic test_register_extremes;
      drain();
      load_settings(10'd127, 10'd1023);
      scan(4'b0001, 16'd100);
      scan(4'b0001, 16'd100);
      scan(4'b1000, 16'd101);
      drain();
      load_settings(10'd0, 10'd0);
      scan(4'b0011, 16'd200);
      scan(4'b0100, 16'd201);
      drain();
      load_settings(10'h3FF, 10'd1);
      scan(4'b1111, 16'd202);
      drain();
      load_settings({3'b000, BASE_RESET}, ACCEL_RESET);
   endtask

   task automatic test_random_scans;
      int                    moved;
      int                    produced;
      int                    phase;
      logic [3:0]            flips;
      logic [AccelWidth-1:0] base_value;
      logic [AccelWidth-1:0] accel_value;
      for (phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: begin
               base_value  = 10'd127;
               accel_value = 10'd1023;
            end
            1: begin
               base_value  = 10'd0;
               accel_value = 10'd0;
            end
            2: begin
               base_value  = 10'd0;
               accel_value = 10'd1023;
            end
            3: begin
               base_value  = 10'h3FF;
               accel_value = 10'd0;
            end
            default: begin
               base_value  = 10'($urandom);
               accel_value = 10'($urandom);
            end
         endcase
         load_settings(base_value, accel_value);
         moved = 0;
         while (moved < 185) begin
            if ($urandom_range(63, 0) == 0) begin
               calm <= ~calm;
            end
            if ($urandom_range(9, 0) == 0) begin
               flips = 4'b0000;
            end else begin
               flips = 4'($urandom);
               if (flips == 4'b0000) begin
                  flips[$urandom_range(3, 0)] = 1'b1;
               end
            end
            if ($urandom_range(15, 0) == 0) begin
               scan_clock = 16'($urandom);
            end else if ($urandom_range(3, 0) == 0) begin
               scan_clock = scan_clock + 16'($urandom_range(1000, 0));
            end else begin
               scan_clock = scan_clock + 16'($urandom_range(12, 0));
            end
            send_scan(flips, scan_clock, produced);
            if (produced > 0) begin
               moved++;
            end
            if ($urandom_range(199, 0) == 0) begin
               drain();
            end
         end
      end
      calm <= 1'b0;
   endtask

   // result stall: draw a random wait after each accepted result, none while calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (calm) begin
            stall_left <= 0;
            rsp_stall  <= 1'b0;
         end else begin
            stall_left <= $urandom_range(MaxGap, 0);
            rsp_stall  <= 1'b0;
         end
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_moves.size() == 0) begin
            if (mismatches < 10) begin
               $display("tb: unexpected result axis %0d delta %0d last %0d",
                        rsp_data.axis, rsp_data.delta, rsp_data.last);
            end
            mismatches++;
         end else begin
            want = expected_moves.pop_front();
            if (rsp_data.axis !== want.axis || rsp_data.delta !== want.delta
                || rsp_data.last !== want.last) begin
               if (mismatches < 10) begin
                  $display("tb: mismatch expected axis %0d delta %0d last %0d, got axis %0d delta %0d last %0d",
                           want.axis, want.delta, want.last,
                           rsp_data.axis, rsp_data.delta, rsp_data.last);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_pulses();
      test_axis_conflicts();
      test_time_wrap();
      test_register_extremes();
      test_random_scans();
      drain();
      if (mismatches == 0 && expected_moves.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
